### sv/tlci_pkg.sv
// ----------------------------------------------------------------------------
// tlci_pkg
// Shared types and widths for the two-landmark circle intersection block.
// ----------------------------------------------------------------------------
package tlci_pkg;

  localparam int IN_W   = 112;  // packed input beat, whole bytes
  localparam int OUT_W  = 32;
  localparam int USER_W = 2;

  // Classified item handed from the front end to the arithmetic back end
  typedef struct packed {
    logic signed [14:0] x1;
    logic signed [14:0] y1;
    logic        [14:0] r1;
    logic        [14:0] r2;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [1:0]  sgn;   // side: +1, -1 or 0
    logic               same;  // coincident landmarks
  } tlci_item_t;

endpackage

### sv/tlci_front.sv
// ----------------------------------------------------------------------------
// tlci_front
// Input stage: unpacks a request, forms the baseline and picks the side.
// ----------------------------------------------------------------------------
module tlci_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [tlci_pkg::IN_W-1:0] s_axis_tdata,
  output logic                      push,
  output tlci_pkg::tlci_item_t      push_item,
  input  logic                      full
);
  import tlci_pkg::*;

  logic               fv;
  tlci_item_t         item;
  tlci_item_t         item_next;
  logic signed [8:0]  b1;
  logic signed [8:0]  b2;
  logic signed [14:0] x2;
  logic signed [14:0] y2;

  always_comb begin
    b1 = s_axis_tdata[23:15];
    b2 = s_axis_tdata[77:69];
    x2 = s_axis_tdata[92:78];
    y2 = s_axis_tdata[107:93];
    item_next.r1 = s_axis_tdata[14:0];
    item_next.x1 = s_axis_tdata[38:24];
    item_next.y1 = s_axis_tdata[53:39];
    item_next.r2 = s_axis_tdata[68:54];
    item_next.dx = 16'(x2) - 16'(item_next.x1);
    item_next.dy = 16'(y2) - 16'(item_next.y1);
    if (b2 > b1) begin
      item_next.sgn = 2'sd1;
    end else if (b2 < b1) begin
      item_next.sgn = -2'sd1;
    end else begin
      item_next.sgn = 2'sd0;
    end
    item_next.same = (item_next.dx == 16'sd0) && (item_next.dy == 16'sd0);
  end

  assign s_axis_tready = !fv || !full;
  assign push          = fv && !full;
  assign push_item     = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_axis_tready) begin
      fv <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item <= item_next;
    end
  end

endmodule

### sv/tlci_queue.sv
// ----------------------------------------------------------------------------
// tlci_queue
// Short queue between front end and back end.
// ----------------------------------------------------------------------------
module tlci_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tlci_pkg::tlci_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output tlci_pkg::tlci_item_t pop_item,
  output logic                 empty
);
  import tlci_pkg::*;

  tlci_item_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/tlci_back.sv
// ----------------------------------------------------------------------------
// tlci_back
// Arithmetic pipeline: squares, radicand, 32-stage square root, 34-stage
// dividers, rounding and saturation. Whole pipe advances on one enable.
// ----------------------------------------------------------------------------
module tlci_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  tlci_pkg::tlci_item_t        pop_item,
  output logic                        pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tlci_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic [tlci_pkg::USER_W-1:0] m_axis_tuser
);
  import tlci_pkg::*;

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 34;

  typedef struct packed {
    logic signed [14:0] x1;
    logic signed [14:0] y1;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [1:0]  sgn;
    logic               same;
    logic               apart;
    logic        [31:0] d2;
    logic signed [49:0] nx;
    logic signed [49:0] ny;
  } sq_side_t;

  typedef struct packed {
    logic signed [14:0] x1;
    logic signed [14:0] y1;
    logic               same;
    logic               apart;
    logic        [32:0] den;
    logic               negx;
    logic               negy;
  } dv_side_t;

  logic en;
  assign en  = !m_axis_tvalid || m_axis_tready;
  assign pop = en && !empty;

  // stage 1: squares
  logic               v1;
  tlci_item_t         it1;
  logic        [31:0] dxx1;
  logic        [31:0] dyy1;
  logic        [29:0] r1sq1;
  logic        [29:0] r2sq1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pop;
    end
    if (en) begin
      it1   <= pop_item;
      dxx1  <= 32'(pop_item.dx * pop_item.dx);
      dyy1  <= 32'(pop_item.dy * pop_item.dy);
      r1sq1 <= pop_item.r1 * pop_item.r1;
      r2sq1 <= pop_item.r2 * pop_item.r2;
    end
  end

  // stage 2: baseline length squared and foot numerator
  logic               v2;
  tlci_item_t         it2;
  logic        [31:0] d2_2;
  logic signed [33:0] n2;
  logic        [29:0] r1sq2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      it2   <= it1;
      d2_2  <= dxx1 + dyy1;
      n2    <= $signed({4'd0, r1sq1}) - $signed({4'd0, r2sq1})
               + $signed({2'd0, dxx1 + dyy1});
      r1sq2 <= r1sq1;
    end
  end

  // stage 3: wide products
  logic               v3;
  tlci_item_t         it3;
  logic        [31:0] d2_3;
  logic        [63:0] nsq3;
  logic        [63:0] big3;
  logic signed [49:0] nx3;
  logic signed [49:0] ny3;
  logic signed [67:0] nsq_full;
  assign nsq_full = n2 * n2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      it3  <= it2;
      d2_3 <= d2_2;
      nsq3 <= nsq_full[63:0];
      big3 <= {62'(r1sq2 * d2_2), 2'b00};
      nx3  <= n2 * it2.dx;
      ny3  <= n2 * it2.dy;
    end
  end

  // square root pipe; index 0 is the radicand stage
  logic     [63:0] sq_rad  [SQ_STEPS+1];
  logic     [34:0] sq_rem  [SQ_STEPS+1];
  logic     [31:0] sq_root [SQ_STEPS+1];
  sq_side_t        sq_sd   [SQ_STEPS+1];
  logic            sq_v    [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v3;
    end
    if (en) begin
      sq_rad[0]      <= big3 - nsq3;
      sq_rem[0]      <= '0;
      sq_root[0]     <= '0;
      sq_sd[0].x1    <= it3.x1;
      sq_sd[0].y1    <= it3.y1;
      sq_sd[0].dx    <= it3.dx;
      sq_sd[0].dy    <= it3.dy;
      sq_sd[0].sgn   <= it3.sgn;
      sq_sd[0].same  <= it3.same;
      sq_sd[0].apart <= big3 < nsq3;
      sq_sd[0].d2    <= d2_3;
      sq_sd[0].nx    <= nx3;
      sq_sd[0].ny    <= ny3;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    assign rem_sh = {sq_rem[k][32:0], sq_rad[k][63:62]};
    assign trial  = {1'b0, sq_root[k], 2'b01};
    assign ge     = rem_sh >= trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
      if (en) begin
        sq_rad[k+1]  <= {sq_rad[k][61:0], 2'b00};
        sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
        sq_root[k+1] <= {sq_root[k][30:0], ge};
        sq_sd[k+1]   <= sq_sd[k];
      end
    end
  end

  // root times baseline components
  logic               v5;
  sq_side_t           sd5;
  logic signed [48:0] rdx5;
  logic signed [48:0] rdy5;
  logic signed [32:0] root_s;
  assign root_s = sq_sd[SQ_STEPS].apart ? 33'sd0 : $signed({1'b0, sq_root[SQ_STEPS]});
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= sq_v[SQ_STEPS];
    end
    if (en) begin
      sd5  <= sq_sd[SQ_STEPS];
      rdx5 <= root_s * sq_sd[SQ_STEPS].dx;
      rdy5 <= root_s * sq_sd[SQ_STEPS].dy;
    end
  end

  // numerators
  logic               v6;
  sq_side_t           sd6;
  logic signed [51:0] numx6;
  logic signed [51:0] numy6;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      sd6 <= sd5;
      case (sd5.sgn)
        2'sd1: begin
          numx6 <= 52'(sd5.nx) - 52'(rdy5);
          numy6 <= 52'(sd5.ny) + 52'(rdx5);
        end
        -2'sd1: begin
          numx6 <= 52'(sd5.nx) + 52'(rdy5);
          numy6 <= 52'(sd5.ny) - 52'(rdx5);
        end
        default: begin
          numx6 <= 52'(sd5.nx);
          numy6 <= 52'(sd5.ny);
        end
      endcase
    end
  end

  // magnitudes plus half divisor for rounding
  logic        [51:0] magx;
  logic        [51:0] magy;
  assign magx = (numx6 < 0 ? 52'(-numx6) : 52'(numx6)) + 52'(sd6.d2);
  assign magy = (numy6 < 0 ? 52'(-numy6) : 52'(numy6)) + 52'(sd6.d2);

  // dividers; index 0 is the setup stage
  logic     [32:0] dvx_rem [DIV_STEPS+1];
  logic     [33:0] dvx_q   [DIV_STEPS+1];
  logic     [32:0] dvy_rem [DIV_STEPS+1];
  logic     [33:0] dvy_q   [DIV_STEPS+1];
  dv_side_t        dv_sd   [DIV_STEPS+1];
  logic            dv_v    [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= v6;
    end
    if (en) begin
      // quotient fits 34 bits, so the upper dividend bits are below the divisor
      dvx_rem[0]     <= 33'(magx[51:DIV_STEPS]);
      dvx_q[0]       <= magx[DIV_STEPS-1:0];
      dvy_rem[0]     <= 33'(magy[51:DIV_STEPS]);
      dvy_q[0]       <= magy[DIV_STEPS-1:0];
      dv_sd[0].x1    <= sd6.x1;
      dv_sd[0].y1    <= sd6.y1;
      dv_sd[0].same  <= sd6.same;
      dv_sd[0].apart <= sd6.apart;
      dv_sd[0].den   <= {sd6.d2, 1'b0};
      dv_sd[0].negx  <= numx6 < 0;
      dv_sd[0].negy  <= numy6 < 0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
    logic [33:0] xsh;
    logic [33:0] ysh;
    logic        xge;
    logic        yge;
    assign xsh = {dvx_rem[k], dvx_q[k][DIV_STEPS-1]};
    assign ysh = {dvy_rem[k], dvy_q[k][DIV_STEPS-1]};
    assign xge = xsh >= {1'b0, dv_sd[k].den};
    assign yge = ysh >= {1'b0, dv_sd[k].den};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
      if (en) begin
        dvx_rem[k+1] <= xge ? 33'(xsh - {1'b0, dv_sd[k].den}) : 33'(xsh);
        dvy_rem[k+1] <= yge ? 33'(ysh - {1'b0, dv_sd[k].den}) : 33'(ysh);
        dvx_q[k+1]   <= {dvx_q[k][DIV_STEPS-2:0], xge};
        dvy_q[k+1]   <= {dvy_q[k][DIV_STEPS-2:0], yge};
        dv_sd[k+1]   <= dv_sd[k];
      end
    end
  end

  // sign, offset, saturate
  dv_side_t           fsd;
  logic signed [35:0] qx;
  logic signed [35:0] qy;
  logic signed [35:0] sx;
  logic signed [35:0] sy;
  logic signed [15:0] px;
  logic signed [15:0] py;

  always_comb begin
    fsd = dv_sd[DIV_STEPS];
    qx  = $signed({2'b00, dvx_q[DIV_STEPS]});
    qy  = $signed({2'b00, dvy_q[DIV_STEPS]});
    sx  = 36'(fsd.x1) + (fsd.negx ? -qx : qx);
    sy  = 36'(fsd.y1) + (fsd.negy ? -qy : qy);
    if (sx > 36'sd32767) begin
      px = 16'sh7fff;
    end else if (sx < -36'sd32768) begin
      px = -16'sh8000;
    end else begin
      px = sx[15:0];
    end
    if (sy > 36'sd32767) begin
      py = 16'sh7fff;
    end else if (sy < -36'sd32768) begin
      py = -16'sh8000;
    end else begin
      py = sy[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v[DIV_STEPS];
    end
    if (en) begin
      if (fsd.same) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 2'b10;
      end else begin
        m_axis_tdata <= {py, px};
        m_axis_tuser <= {1'b0, fsd.apart};
      end
    end
  end

endmodule

### sv/two_landmark_circle_intersection.sv
// ----------------------------------------------------------------------------
// two_landmark_circle_intersection
// Position fix from two landmarks by intersecting their range circles.
//
// channel   dir  width  fields (lowest bit up)
// s_axis    in   112    flag1_range, flag1_bearing, flag1_x, flag1_y,
//                       flag2_range, flag2_bearing, flag2_x, flag2_y, pad
// m_axis    out  32     pos_x, pos_y; tuser: circles_apart, same_landmark
//
// One request per cycle sustained while results are accepted; each result passes
// through the 32-step square root and 34-step divider pipes.
// rst is synchronous and clears all valid flags and the queue.
// A stalled result freezes the back end; the four-entry queue and input
// register keep taking requests until they fill.
// ----------------------------------------------------------------------------
module two_landmark_circle_intersection (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tlci_pkg::IN_W-1:0]   s_axis_tdata,  // see table above
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tlci_pkg::OUT_W-1:0]  m_axis_tdata,  // pos_x, pos_y
  output logic [tlci_pkg::USER_W-1:0] m_axis_tuser   // circles_apart, same_landmark
);
  import tlci_pkg::*;

  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  tlci_item_t push_item;
  tlci_item_t pop_item;

  tlci_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push          (push),
    .push_item     (push_item),
    .full          (full)
  );

  tlci_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  tlci_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .pop_item      (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
